[hw/rtl/lap_pkg.sv]
// Shared types and constants for the 3x3 Laplacian filter.
package lap_pkg;

  localparam int unsigned PixW         = 16;
  localparam int unsigned OutW         = 15;
  localparam int unsigned LapMaxWidth  = 32768;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned WidthRegW    = 16;
  localparam int unsigned DecRegW      = 3;

  localparam logic [WidthRegW-1:0] LineWidthRst  = 16'd4096;
  localparam logic [DecRegW-1:0]   DecimationRst = 3'd2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegLineWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDecimation = 1'b1;

  // one window column: pixel two rows up, one row up, current row
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } lap_col_t;

endpackage

[hw/rtl/laplacian_filter_3x3_top.sv]
// Top level of the 3x3 Laplacian filter with output decimation.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid_i / s_axis_tready_o | tdata = pixel, tuser = start_of_frame
//  m_axis    | out | m_axis_tvalid_o / m_axis_tready_i | tdata = filtered, tlast = last_in_row
//  cfg       | in  | cfg_we_i (no wait)                | cfg_idx_i, cfg_data_i
//
// One pixel per clock when not stalled: separate line store read and write ports, with a
// bypass for a read that hits the write still in flight. A result passes through stage 1,
// stage 2 and the output register to m_axis. After reset and every configuration write a
// remainder sweep (one bit per cycle) recomputes the decimation phases and the last output
// column; s_axis_tready_o stays low meanwhile. A stalled output holds its beat; pixels keep
// entering until stage 1, stage 2 and the output register each hold a result.
module laplacian_filter_3x3_top import lap_pkg::*; #(
  parameter int unsigned MAX_WIDTH = LapMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [PixW-1:0]     s_axis_tdata_i,   // [15:0] pixel
  input  logic                s_axis_tuser_i,   // [0] start_of_frame
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,   // [14:0] filtered, [15] zero fill
  output logic                m_axis_tlast_o,   // last_in_row
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW     = 17;            // effective width and column compare
  localparam int unsigned StepW  = $clog2(WW);
  localparam logic [WW-1:0]    MaxW     = WW'(MAX_WIDTH);
  localparam logic [StepW-1:0] LastStep = StepW'(WW - 1);

  // One restoring-division step: shift in a bit, subtract the divisor if it fits.
  function automatic logic [DecRegW-1:0] rem_step(input logic [DecRegW-1:0] rem,
                                                  input logic               b,
                                                  input logic [DecRegW-1:0] dv);
    logic [DecRegW:0] r;
    r = {rem, b};
    if (r >= {1'b0, dv}) begin
      r = r - {1'b0, dv};
    end
    return r[DecRegW-1:0];
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [WidthRegW-1:0] lw_q;
  logic [DecRegW-1:0]   dec_q;
  logic [WW-1:0]        weff;
  logic [DecRegW-1:0]   dec_eff;
  logic [DecRegW-1:0]   one_mod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= LineWidthRst;
      dec_q <= DecimationRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLineWidth:  lw_q  <= cfg_data_i[WidthRegW-1:0];
        RegDecimation: dec_q <= cfg_data_i[DecRegW-1:0];
        default: ;
      endcase
    end
  end

  assign weff    = ({1'b0, lw_q} > MaxW) ? MaxW : {1'b0, lw_q};
  assign dec_eff = (dec_q == '0) ? DecRegW'(1) : dec_q;
  assign one_mod = (dec_eff == DecRegW'(1)) ? '0 : DecRegW'(1);

  // ---------------------------------------------------------------- counters and phases
  logic [WidthRegW-1:0] col_q, col_d, row_q, row_d;
  logic [DecRegW-1:0]   cph_q, cph_d, rph_q, rph_d, rw_q, rw_d;
  logic                 busy_q, busy_d;
  logic [StepW-1:0]     step_q, step_d;

  logic [WidthRegW-1:0] col_c, row_c;
  logic [DecRegW-1:0]   cph_c, rph_c;
  logic [WW-1:0]        col_inc, wm2, lastc1;
  logic [WW-1:0]        col_ext, row_ext;
  logic [StepW-1:0]     bitpos;
  logic                 accept;
  logic                 emit_c, last_c;
  logic [AddrW-1:0]     idx_c;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign col_c  = s_axis_tuser_i ? '0 : col_q;
  assign row_c  = s_axis_tuser_i ? '0 : row_q;
  assign cph_c  = s_axis_tuser_i ? '0 : cph_q;
  assign rph_c  = s_axis_tuser_i ? '0 : rph_q;

  assign col_inc = {1'b0, col_c} + WW'(1);
  assign wm2     = weff - WW'(2);
  // last emitted centre column plus one: weff - 1 - ((weff - 2) mod dec)
  assign lastc1  = weff - WW'(1) - WW'(rw_q);
  assign bitpos  = LastStep - step_q;
  assign col_ext = {1'b0, col_q};
  assign row_ext = {1'b0, row_q};

  assign idx_c  = ({1'b0, col_c} < MaxW) ? col_c[AddrW-1:0] : '0;
  assign emit_c = (row_c >= WidthRegW'(2)) && (col_c >= WidthRegW'(2)) &&
                  (weff >= WW'(3)) && (rph_c == one_mod) && (cph_c == one_mod);
  assign last_c = ({1'b0, col_c} == lastc1);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    cph_d  = cph_q;
    rph_d  = rph_q;
    rw_d   = rw_q;
    busy_d = busy_q;
    step_d = step_q;
    if (cfg_we_i) begin
      // restart the phase sweep from the top bit
      busy_d = 1'b1;
      step_d = '0;
      cph_d  = '0;
      rph_d  = '0;
      rw_d   = '0;
    end else if (busy_q) begin
      cph_d  = rem_step(cph_q, col_ext[bitpos], dec_eff);
      rph_d  = rem_step(rph_q, row_ext[bitpos], dec_eff);
      rw_d   = rem_step(rw_q, wm2[bitpos], dec_eff);
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
      end
    end else if (accept) begin
      if (col_inc >= weff) begin
        col_d = '0;
        cph_d = '0;
        if (row_c != '1) begin
          row_d = row_c + WidthRegW'(1);
          rph_d = (rph_c + DecRegW'(1) == dec_eff) ? '0 : rph_c + DecRegW'(1);
        end else begin
          row_d = row_c;
          rph_d = rph_c;
        end
      end else begin
        col_d = col_inc[WidthRegW-1:0];
        cph_d = (cph_c + DecRegW'(1) == dec_eff) ? '0 : cph_c + DecRegW'(1);
        row_d = row_c;
        rph_d = rph_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      rw_q   <= '0;
      busy_q <= 1'b1;
      step_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
      rw_q   <= rw_d;
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic s1_valid_q, s1_emit_q, s1_last_q;
  logic s2_valid_q, s2_last_q;
  logic o_valid_q, o_last_q;
  logic o_free, s2_free, s2_adv, s1_adv, s1_free;

  assign o_free  = !o_valid_q | m_axis_tready_i;
  assign s2_adv  = s2_valid_q & o_free;
  assign s2_free = !s2_valid_q | o_free;
  // a pixel that yields no result leaves stage 1 without a slot in stage 2
  assign s1_adv  = s1_valid_q & (!s1_emit_q | s2_free);
  assign s1_free = !s1_valid_q | s1_adv;
  assign s_axis_tready_o = s1_free & !busy_q;

  // ---------------------------------------------------------------- line stores
  logic [PixW-1:0]   s1_px_q;
  logic [AddrW-1:0]  s1_idx_q;
  logic [2*PixW-1:0] rd_data;
  logic              byp_q;
  logic [2*PixW-1:0] byp_data_q;
  logic [PixW-1:0]   above, above2;

  lap_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (idx_c),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_idx_q),
    .wr_data_i ({s1_px_q, above})
  );

  // word holds {previous row, row before that}; take the in-flight write if it hit
  assign above  = byp_q ? byp_data_q[2*PixW-1:PixW] : rd_data[2*PixW-1:PixW];
  assign above2 = byp_q ? byp_data_q[PixW-1:0]      : rd_data[PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        byp_q      <= s1_valid_q & s1_adv & (s1_idx_q == idx_c);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= s_axis_tdata_i;
      s1_idx_q   <= idx_c;
      s1_emit_q  <= emit_c;
      s1_last_q  <= last_c;
      byp_data_q <= {s1_px_q, above};
    end
  end

  // ---------------------------------------------------------------- window cells
  lap_col_t new_col, col1, col0;

  assign new_col = '{top: above2, mid: above, bot: s1_px_q};

  lap_col_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (new_col),
    .col_o   (col1)
  );

  lap_col_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (col1),
    .col_o   (col0)
  );

  // ---------------------------------------------------------------- kernel, mod 2^16
  logic [PixW-1:0] p_sum, q_sum, s2_p_q, s2_q_q, r_sum;
  logic [OutW-1:0] o_data_q;

  // window part: 8*centre minus the two older columns' remaining taps
  assign p_sum = {col1.mid[PixW-4:0], 3'b000} - col0.top - col0.mid - col0.bot
                 - col1.top - col1.bot;
  // newest column taps
  assign q_sum = above2 + above + s1_px_q;
  assign r_sum = s2_p_q - s2_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (s1_adv && s1_emit_q) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      s2_p_q    <= p_sum;
      s2_q_q    <= q_sum;
      s2_last_q <= s1_last_q;
    end
    if (s2_adv) begin
      // clamp negative wrapped values to zero
      o_data_q <= r_sum[PixW-1] ? '0 : r_sum[OutW-1:0];
      o_last_q <= s2_last_q;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {1'b0, o_data_q};
  assign m_axis_tlast_o  = o_last_q;

endmodule

[hw/rtl/lap_line_mem.sv]
// Line store memory: two stacked image rows per word, one read and one write port.
module lap_line_mem import lap_pkg::*; #(
  parameter int unsigned Depth = LapMaxWidth,
  parameter int unsigned AddrW = $clog2(LapMaxWidth)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [2*PixW-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [2*PixW-1:0] wr_data_i
);

  logic [2*PixW-1:0] mem_q [Depth];
  logic [2*PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/lap_col_cell.sv]
// One window column cell: load a column from the neighbor on each shift.
module lap_col_cell import lap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     shift_i,
  input  lap_col_t col_i,
  output lap_col_t col_o
);

  lap_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule
